### src/rbgi_pkg.sv
// ----------------------------------------------------------------------------
// rbgi_pkg
// Shared types, codes and saturation helpers of the rigid body gravity
// integrator.
// ----------------------------------------------------------------------------
package rbgi_pkg;

  localparam logic [2:0] ACT_GRAV  = 3'd0;
  localparam logic [2:0] ACT_INTEG = 3'd1;
  localparam logic [2:0] ACT_SPIN  = 3'd2;
  localparam logic [2:0] ACT_PUSH  = 3'd3;
  localparam logic [2:0] ACT_LOAD  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] REG_LDAMP = 2'd0;
  localparam logic [1:0] REG_ADAMP = 2'd1;
  localparam logic [1:0] REG_MASS  = 2'd2;
  localparam logic [1:0] REG_GFAC  = 2'd3;

  localparam logic [16:0] LDAMP_RST = 17'd65208;
  localparam logic [16:0] ADAMP_RST = 17'd58982;
  localparam logic [30:0] MASS_RST  = 31'd65536;
  localparam logic [30:0] GFAC_RST  = 31'd32768;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIFF,
    OP_SQ_MUL,
    OP_SQ_ADD,
    OP_RT_INIT,
    OP_RT_STEP,
    OP_R2,
    OP_GM,
    OP_U_INIT,
    OP_DV_STEP,
    OP_P_LO,
    OP_P_HI,
    OP_N_ADD,
    OP_Q_INIT,
    OP_APPLY,
    OP_ZERO,
    OP_INT_POS,
    OP_D_MUL,
    OP_D_APP,
    OP_SPIN,
    OP_PUSH,
    OP_LOAD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic div_ovf;
  } sts_t;

  typedef struct packed {
    logic [16:0] ldamp;
    logic [16:0] adamp;
    logic [30:0] mass;
    logic [30:0] gfac;
  } cfg_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sat_t        r;
    sum   = {a[31], a} + {b[31], b};
    r.ovf = sum[32] ^ sum[31];
    r.val = r.ovf ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];
    return r;
  endfunction

  // Apply a sign to an unsigned magnitude and clamp to the signed 32-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [33:0] mag);
    sat_t r;
    if (neg) begin
      r.ovf = mag > 34'h0_8000_0000;
      r.val = r.ovf ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r.ovf = mag > 34'h0_7fff_ffff;
      r.val = r.ovf ? 32'h7fff_ffff : mag[31:0];
    end
    return r;
  endfunction

endpackage

### src/rbgi_ctrl.sv
// ----------------------------------------------------------------------------
// rbgi_ctrl
// Sequencer: walks one item through the datapath operations and owns both
// handshakes.
// ----------------------------------------------------------------------------
module rbgi_ctrl import rbgi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic       other_valid_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GDIFF = 5'd1;
  localparam logic [4:0] S_GSQ   = 5'd2;
  localparam logic [4:0] S_GZCHK = 5'd3;
  localparam logic [4:0] S_RTS   = 5'd4;
  localparam logic [4:0] S_R2    = 5'd5;
  localparam logic [4:0] S_GM    = 5'd6;
  localparam logic [4:0] S_UINIT = 5'd7;
  localparam logic [4:0] S_USTEP = 5'd8;
  localparam logic [4:0] S_PLO   = 5'd9;
  localparam logic [4:0] S_PHI   = 5'd10;
  localparam logic [4:0] S_NADD  = 5'd11;
  localparam logic [4:0] S_QINIT = 5'd12;
  localparam logic [4:0] S_QSTEP = 5'd13;
  localparam logic [4:0] S_APPLY = 5'd14;
  localparam logic [4:0] S_IPOS  = 5'd15;
  localparam logic [4:0] S_DMUL  = 5'd16;
  localparam logic [4:0] S_DAPP  = 5'd17;
  localparam logic [4:0] S_SPIN  = 5'd18;
  localparam logic [4:0] S_PUSH  = 5'd19;
  localparam logic [4:0] S_LOAD  = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;

  localparam logic [5:0] U_LAST = 6'(FRAC_BITS);

  logic [4:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          cnt_d    = '0;
          k_d      = '0;
          case (action_i)
            ACT_GRAV:  state_d = other_valid_i ? S_GDIFF : S_OUT;
            ACT_INTEG: state_d = S_IPOS;
            ACT_SPIN:  state_d = S_SPIN;
            ACT_PUSH:  state_d = S_PUSH;
            ACT_LOAD:  state_d = S_LOAD;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_GDIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_GSQ;
      end
      S_GSQ: begin
        cmd_o.op  = cnt_q[0] ? OP_SQ_ADD : OP_SQ_MUL;
        cmd_o.idx = cnt_q[2:1];
        cnt_d     = cnt_q + 6'd1;
        if (cnt_q == 6'd5) begin
          state_d = S_GZCHK;
        end
      end
      S_GZCHK: begin
        cnt_d = '0;
        if (sts_i.d_zero) begin
          cmd_o.op = OP_ZERO;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = OP_RT_INIT;
          state_d  = S_RTS;
        end
      end
      S_RTS: begin
        cmd_o.op = OP_RT_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = S_R2;
        end
      end
      S_R2: begin
        cmd_o.op = OP_R2;
        state_d  = S_GM;
      end
      S_GM: begin
        cmd_o.op = OP_GM;
        state_d  = S_UINIT;
      end
      S_UINIT: begin
        cmd_o.op = OP_U_INIT;
        cnt_d    = '0;
        state_d  = S_USTEP;
      end
      S_USTEP: begin
        cmd_o.op = OP_DV_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == U_LAST) begin
          state_d = S_PLO;
        end
      end
      S_PLO: begin
        cmd_o.op = OP_P_LO;
        state_d  = S_PHI;
      end
      S_PHI: begin
        cmd_o.op = OP_P_HI;
        state_d  = S_NADD;
      end
      S_NADD: begin
        cmd_o.op = OP_N_ADD;
        state_d  = S_QINIT;
      end
      S_QINIT: begin
        cmd_o.op = OP_Q_INIT;
        cnt_d    = '0;
        state_d  = S_QSTEP;
      end
      S_QSTEP: begin
        if (sts_i.div_ovf) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.op = OP_DV_STEP;
          cnt_d    = cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            state_d = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd_o.op = OP_APPLY;
        if (k_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_UINIT;
        end
      end
      S_IPOS: begin
        cmd_o.op = OP_INT_POS;
        state_d  = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.op = OP_D_MUL;
        state_d  = S_DAPP;
      end
      S_DAPP: begin
        cmd_o.op = OP_D_APP;
        k_d      = k_q + 2'd1;
        state_d  = (k_q == 2'd3) ? S_OUT : S_DMUL;
      end
      S_SPIN: begin
        cmd_o.op = OP_SPIN;
        state_d  = S_OUT;
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = S_OUT;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

endmodule

### src/rbgi_dp.sv
// ----------------------------------------------------------------------------
// rbgi_dp
// Datapath: body state, one shared multiplier, bit-serial root and divider,
// saturating adders and the result registers.
// ----------------------------------------------------------------------------
module rbgi_dp import rbgi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_z_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] angle_in_i,
  input  logic signed [31:0] spin_in_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] angle_out_o,
  output logic signed [31:0] vel_x_out_o,
  output logic signed [31:0] vel_y_out_o,
  output logic signed [31:0] vel_z_out_o,
  output logic [1:0]         status_o
);

  localparam int UW = FRAC_BITS + 1;
  localparam int NW = 62 + UW;
  localparam int HW = NW - 33;

  logic [31:0] own_q [3];
  logic [31:0] vec_q [3];
  logic [31:0] spn_q;
  logic [31:0] vel_q [3];
  logic [31:0] spin_q;
  logic [31:0] pos_q [3];
  logic [31:0] ang_q;
  logic        sat_q, zero_q;

  logic        neg_q [3];
  logic [30:0] m_q [3];
  logic        s_q;
  logic [63:0] d2_q, prod_q, r2_q;
  logic [61:0] g_q;
  logic [31:0] rt_q;
  logic [34:0] rtrem_q;
  logic [63:0] rtsrc_q;
  logic [63:0] dden_q, drem_q;
  logic [32:0] dnum_q, dquo_q;
  logic        ovf_q;
  logic [NW-1:0] n_q;

  // combinational helpers
  logic [32:0] diff [3];
  logic [32:0] mag [3];
  logic        s_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [34:0] rt_sh, rt_trial;
  logic [64:0] dv_sh, dv_sub;
  logic        dv_ge;
  logic [NW-1:0] nsh;
  logic [63:0] hiq;
  logic [32:0] qv;
  sat_t        term, vsum, dres, asum;
  sat_t        psum [3];
  logic [31:0] dv_v;
  logic [UW-1:0] u_c;
  logic [1:0]  ix;
  logic [1:0]  ax;

  assign ix  = cmd_i.idx;
  // axis index: the spin slot folds onto z for the vector arrays
  assign ax  = ix[1] ? 2'd2 : ix;
  assign u_c = dquo_q[UW-1:0];

  always_comb begin
    s_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      diff[k] = {vec_q[k][31], vec_q[k]} - {own_q[k][31], own_q[k]};
      mag[k]  = diff[k][32] ? (~diff[k] + 33'd1) : diff[k];
      s_c     = s_c | mag[k][31];
      psum[k] = sat_add(own_q[k], vel_q[k]);
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dv_v  = (ix == 2'd3) ? spin_q : vel_q[ax];
    case (cmd_i.op)
      OP_SQ_MUL: begin
        mul_a = {1'b0, m_q[ax]};
        mul_b = {1'b0, m_q[ax]};
      end
      OP_R2: begin
        mul_a = rt_q;
        mul_b = rt_q;
      end
      OP_GM: begin
        mul_a = {1'b0, cfg_i.gfac};
        mul_b = {1'b0, cfg_i.mass};
      end
      OP_P_LO: begin
        mul_a = {1'b0, g_q[30:0]};
        mul_b = 32'(u_c);
      end
      OP_P_HI: begin
        mul_a = {1'b0, g_q[61:31]};
        mul_b = 32'(u_c);
      end
      OP_D_MUL: begin
        mul_a = dv_v[31] ? (~dv_v + 32'd1) : dv_v;
        mul_b = 32'((ix == 2'd3) ? cfg_i.adamp : cfg_i.ldamp);
      end
      default: ;
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    rt_sh    = {rtrem_q[32:0], rtsrc_q[63:62]};
    rt_trial = {1'b0, rt_q, 2'b01};
    dv_sh    = {drem_q, dnum_q[32]};
    dv_sub   = dv_sh - {1'b0, dden_q};
    dv_ge    = dv_sh >= {1'b0, dden_q};
    nsh      = s_q ? (n_q >> 2) : n_q;
    hiq      = 64'(nsh[NW-1:33]);
    qv       = (ovf_q || dquo_q > 33'h1_0000_0000) ? 33'h1_0000_0000 : dquo_q;
    term     = sat_mag(neg_q[ax], {1'b0, qv});
    vsum     = sat_add(vel_q[ax], term.val);
    dres     = sat_mag(dv_v[31], {1'b0, prod_q[48:16]});
    asum     = sat_add(ang_q, spin_q);
  end

  assign sts_o.d_zero  = (d2_q == '0);
  assign sts_o.div_ovf = ovf_q;

  // body state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        vel_q[k] <= '0;
      end
      spin_q <= '0;
      sat_q  <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LATCH: begin
          sat_q  <= 1'b0;
          zero_q <= 1'b0;
        end
        OP_ZERO: zero_q <= 1'b1;
        OP_APPLY: begin
          vel_q[ax] <= vsum.val;
          sat_q <= sat_q | term.ovf | vsum.ovf;
        end
        OP_INT_POS: begin
          sat_q <= sat_q | psum[0].ovf | psum[1].ovf | psum[2].ovf | asum.ovf;
        end
        OP_D_APP: begin
          if (ix == 2'd3) begin
            spin_q <= dres.val;
          end else begin
            vel_q[ax] <= dres.val;
          end
          sat_q <= sat_q | dres.ovf;
        end
        OP_SPIN: begin
          spin_q <= sat_add(spin_q, spn_q).val;
          sat_q  <= sat_add(spin_q, spn_q).ovf;
        end
        OP_PUSH: begin
          for (int k = 0; k < 3; k++) begin
            vel_q[k] <= sat_add(vel_q[k], vec_q[k]).val;
          end
          sat_q <= sat_add(vel_q[0], vec_q[0]).ovf | sat_add(vel_q[1], vec_q[1]).ovf
                 | sat_add(vel_q[2], vec_q[2]).ovf;
        end
        OP_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            vel_q[k] <= vec_q[k];
          end
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        own_q[0] <= own_x_i;
        own_q[1] <= own_y_i;
        own_q[2] <= own_z_i;
        vec_q[0] <= vec_x_i;
        vec_q[1] <= vec_y_i;
        vec_q[2] <= vec_z_i;
        spn_q    <= spin_in_i;
        ang_q    <= angle_in_i;
        pos_q[0] <= own_x_i;
        pos_q[1] <= own_y_i;
        pos_q[2] <= own_z_i;
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= diff[k][32];
          m_q[k]   <= s_c ? mag[k][31:1] : mag[k][30:0];
        end
        s_q  <= s_c;
        d2_q <= '0;
      end
      OP_SQ_MUL: prod_q <= mul_p;
      OP_SQ_ADD: d2_q   <= d2_q + prod_q;
      OP_RT_INIT: begin
        rtsrc_q <= d2_q;
        rtrem_q <= '0;
        rt_q    <= '0;
      end
      OP_RT_STEP: begin
        rtsrc_q <= {rtsrc_q[61:0], 2'b00};
        if (rt_sh >= rt_trial) begin
          rtrem_q <= rt_sh - rt_trial;
          rt_q    <= {rt_q[30:0], 1'b1};
        end else begin
          rtrem_q <= rt_sh;
          rt_q    <= {rt_q[30:0], 1'b0};
        end
      end
      OP_R2: r2_q <= mul_p;
      OP_GM: g_q  <= mul_p[61:0];
      OP_U_INIT: begin
        drem_q <= 64'(m_q[ax] >> 1);
        dnum_q <= {m_q[ax][0], 32'd0};
        dden_q <= 64'(rt_q);
        dquo_q <= '0;
      end
      OP_DV_STEP: begin
        drem_q <= dv_ge ? dv_sub[63:0] : dv_sh[63:0];
        dnum_q <= {dnum_q[31:0], 1'b0};
        dquo_q <= {dquo_q[31:0], dv_ge};
      end
      OP_P_LO: prod_q <= mul_p;
      OP_P_HI: begin
        n_q    <= NW'(prod_q);
        prod_q <= mul_p;
      end
      OP_N_ADD: n_q <= n_q + NW'({prod_q, 31'd0});
      OP_Q_INIT: begin
        ovf_q  <= hiq >= r2_q;
        drem_q <= hiq;
        dnum_q <= nsh[32:0];
        dden_q <= r2_q;
        dquo_q <= '0;
      end
      OP_INT_POS: begin
        for (int k = 0; k < 3; k++) begin
          pos_q[k] <= psum[k].val;
        end
        ang_q <= asum.val;
      end
      OP_D_MUL: prod_q <= mul_p;
      default: ;
    endcase
  end

  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign angle_out_o = ang_q;
  assign vel_x_out_o = vel_q[0];
  assign vel_y_out_o = vel_q[1];
  assign vel_z_out_o = vel_q[2];
  assign status_o    = zero_q ? ST_ZERO : (sat_q ? ST_SAT : ST_OK);

endmodule

### src/rigid_body_gravity_integrator_top.sv
// ----------------------------------------------------------------------------
// rigid_body_gravity_integrator_top
// One body's velocity and spin rate in fixed point: gravity term, integrate,
// spin, push and velocity load, with an APB register port for damping, mass
// and gravity strength.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                     | beat
//   ---------+-------------------------------+-----------------------------
//   input    | in_valid_i / in_stall_o       | action, own, vec, angle, spin
//   output   | out_valid_o / out_stall_i     | pos, angle, velocity, status
//   config   | psel/penable/pwrite, pready=1 | 4 registers at 4*index
//
// One item at a time. A gravity term runs the 32-step bit-serial square
// root and, per axis, a FRAC_BITS+1 step and a 33-step restoring divide on
// one shared 65-bit subtractor; the second divide is skipped when its
// quotient overflows. Integrate runs four damping products through the
// single multiplier.
// Reset clears velocity, spin rate and registers to their reset values.
// A result beat holds on the output while out_stall_i is high; the input
// stays stalled until that beat leaves.
module rigid_body_gravity_integrator_top import rbgi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_z_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic               other_valid_i,
  input  logic signed [31:0] angle_in_i,
  input  logic signed [31:0] spin_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] angle_out_o,
  output logic signed [31:0] vel_x_out_o,
  output logic signed [31:0] vel_y_out_o,
  output logic signed [31:0] vel_z_out_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  // APB register file: always ready, write on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ldamp <= LDAMP_RST;
      cfg_q.adamp <= ADAMP_RST;
      cfg_q.mass  <= MASS_RST;
      cfg_q.gfac  <= GFAC_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LDAMP: cfg_q.ldamp <= pwdata[16:0];
        REG_ADAMP: cfg_q.adamp <= pwdata[16:0];
        REG_MASS:  cfg_q.mass  <= pwdata[30:0];
        REG_GFAC:  cfg_q.gfac  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LDAMP: prdata = 32'(cfg_q.ldamp);
      REG_ADAMP: prdata = 32'(cfg_q.adamp);
      REG_MASS:  prdata = 32'(cfg_q.mass);
      REG_GFAC:  prdata = 32'(cfg_q.gfac);
      default:   prdata = '0;
    endcase
  end

  rbgi_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .other_valid_i(other_valid_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  rbgi_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg_q),
    .own_x_i    (own_x_i),
    .own_y_i    (own_y_i),
    .own_z_i    (own_z_i),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .angle_in_i (angle_in_i),
    .spin_in_i  (spin_in_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .angle_out_o(angle_out_o),
    .vel_x_out_o(vel_x_out_o),
    .vel_y_out_o(vel_y_out_o),
    .vel_z_out_o(vel_z_out_o),
    .status_o   (status_o)
  );

endmodule

### sim/rbgi_checker.sv
// ----------------------------------------------------------------------------
// rbgi_checker
// Watches the input, output and register ports of the gravity integrator,
// predicts every result beat in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module rbgi_checker import rbgi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_z_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic               other_valid_i,
  input  logic signed [31:0] angle_in_i,
  input  logic signed [31:0] spin_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] angle_out_i,
  input  logic signed [31:0] vel_x_out_i,
  input  logic signed [31:0] vel_y_out_i,
  input  logic signed [31:0] vel_z_out_i,
  input  logic [1:0]         status_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 beats_checked_o,
  output int                 zero_dist_seen_o,
  output int                 saturated_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] angle;
    logic signed [31:0] vel [3];
    logic [1:0]         status;
  } body_beat_t;

  body_beat_t         expected_q[$];
  logic [16:0]        ldamp, adamp;
  logic [30:0]        mass, gfac;
  logic signed [31:0] velocity [3];
  logic signed [31:0] spin_rate;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                 inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] damped(input logic signed [31:0] v,
                                                input logic [16:0] f, inout logic ovf);
    logic signed [63:0] wide, res;
    logic [63:0]        mag;
    wide = v;
    mag  = (wide < 0) ? -wide : wide;
    res  = (mag * f) >> 16;
    return clamp32((wide < 0) ? -res : res, ovf);
  endfunction

  // Advance the body by one beat and return what the block should report.
  function automatic body_beat_t advance_body();
    body_beat_t         e;
    logic               ovf, s;
    logic signed [31:0] own [3], vec [3];
    logic signed [63:0] d [3], sum;
    logic [63:0]        m [3], dist2, r, r2, g, u;
    logic [127:0]       prod, q;
    own = '{own_x_i, own_y_i, own_z_i};
    vec = '{vec_x_i, vec_y_i, vec_z_i};
    ovf = 1'b0;
    e.pos    = own;
    e.angle  = angle_in_i;
    e.vel    = velocity;
    e.status = ST_OK;
    case (action_i)
      ACT_GRAV: begin
        if (other_valid_i) begin
          s = 1'b0;
          for (int k = 0; k < 3; k++) begin
            d[k] = 64'(vec[k]) - 64'(own[k]);
            m[k] = (d[k] < 0) ? -d[k] : d[k];
            if (m[k] >= (64'd1 << 31)) s = 1'b1;
          end
          dist2 = '0;
          for (int k = 0; k < 3; k++) begin
            m[k]  = m[k] >> s;
            dist2 = dist2 + m[k] * m[k];
          end
          if (dist2 == 0) begin
            e.status = ST_ZERO;
          end else begin
            r  = root64(dist2);
            r2 = r * r;
            g  = 64'(gfac) * 64'(mass);
            for (int k = 0; k < 3; k++) begin
              u    = (m[k] << FRAC) / r;
              prod = {64'd0, g} * {64'd0, u};
              if (s) prod = prod >> 2;
              q = prod / {64'd0, r2};
              if (q > (128'd1 << 32)) q = 128'd1 << 32;
              sum = (d[k] < 0) ? -64'(q[32:0]) : 64'(q[32:0]);
              sum = 64'(clamp32(sum, ovf));
              e.vel[k] = clamp32(64'(e.vel[k]) + sum, ovf);
            end
          end
        end
      end
      ACT_INTEG: begin
        for (int k = 0; k < 3; k++) begin
          e.pos[k] = clamp32(64'(own[k]) + 64'(e.vel[k]), ovf);
          e.vel[k] = damped(e.vel[k], ldamp, ovf);
        end
        e.angle   = clamp32(64'(angle_in_i) + 64'(spin_rate), ovf);
        spin_rate = damped(spin_rate, adamp, ovf);
      end
      ACT_SPIN:  spin_rate = clamp32(64'(spin_rate) + 64'(spin_in_i), ovf);
      ACT_PUSH: begin
        for (int k = 0; k < 3; k++) e.vel[k] = clamp32(64'(e.vel[k]) + 64'(vec[k]), ovf);
      end
      ACT_LOAD:  e.vel = vec;
      default: ;
    endcase
    if (e.status == ST_OK && ovf) e.status = ST_SAT;
    velocity = e.vel;
    return e;
  endfunction

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $realtime, what, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_beat_t e;
    logic signed [31:0] got_pos [3], got_vel [3];
    if (!rst_ni) begin
      ldamp     = LDAMP_RST;
      adamp     = ADAMP_RST;
      mass      = MASS_RST;
      gfac      = GFAC_RST;
      velocity  = '{32'sd0, 32'sd0, 32'sd0};
      spin_rate = '0;
      expected_q.delete();
      fail_count_o     = 0;
      beats_checked_o  = 0;
      zero_dist_seen_o = 0;
      saturated_seen_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_LDAMP: ldamp = pwdata_i[16:0];
          REG_ADAMP: adamp = pwdata_i[16:0];
          REG_MASS:  mass  = pwdata_i[30:0];
          REG_GFAC:  gfac  = pwdata_i[30:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          got_pos = '{pos_x_i, pos_y_i, pos_z_i};
          got_vel = '{vel_x_out_i, vel_y_out_i, vel_z_out_i};
          for (int k = 0; k < 3; k++) begin
            if (got_pos[k] !== e.pos[k]) report($sformatf("pos[%0d]", k), e.pos[k], got_pos[k]);
            if (got_vel[k] !== e.vel[k]) report($sformatf("vel[%0d]", k), e.vel[k], got_vel[k]);
          end
          if (angle_out_i !== e.angle) report("angle", e.angle, angle_out_i);
          if (status_i !== e.status) report("status", 32'(e.status), 32'(status_i));
          beats_checked_o++;
          if (e.status == ST_ZERO) zero_dist_seen_o++;
          if (e.status == ST_SAT) saturated_seen_o++;
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(advance_body());
    end
    pending_o = expected_q.size();
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression of the rigid body gravity integrator: directed corner beats and
// random sequences under several register settings, with bursty input,
// random output stalls and a long output hold-off in each random phase.
// ----------------------------------------------------------------------------
module tb;
  import rbgi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes outside the defined set; the block must echo and do nothing.
  localparam logic [2:0] ACT_BAD_LO = 3'd5;
  localparam logic [2:0] ACT_BAD_HI = 3'd7;
  localparam int         IDLE_LIMIT = 6000;
  localparam int         LONG_HOLD  = 1500;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] own [3];
    logic signed [31:0] vec [3];
    logic               other_valid;
    logic signed [31:0] angle;
    logic signed [31:0] spin;
  } body_cmd_t;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic [2:0]         action_i;
  logic signed [31:0] own_x_i, own_y_i, own_z_i, vec_x_i, vec_y_i, vec_z_i;
  logic               other_valid_i;
  logic signed [31:0] angle_in_i, spin_in_i;
  logic               out_valid_o, out_stall_i;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, angle_out_o;
  logic signed [31:0] vel_x_out_o, vel_y_out_o, vel_z_out_o;
  logic [1:0]         status_o;
  logic               psel, penable, pwrite, pready;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;

  int fail_count, pending, beats_checked, zero_dist_seen, saturated_seen;
  int beats_sent, burst_left, hold_request, stall_pct;
  bit run_done;

  rigid_body_gravity_integrator_top u_top (.*);

  rbgi_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i,
    .own_x_i, .own_y_i, .own_z_i, .vec_x_i, .vec_y_i, .vec_z_i,
    .other_valid_i, .angle_in_i, .spin_in_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .angle_out_i(angle_out_o), .vel_x_out_i(vel_x_out_o),
    .vel_y_out_i(vel_y_out_o), .vel_z_out_i(vel_z_out_o), .status_i(status_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending),
    .beats_checked_o(beats_checked), .zero_dist_seen_o(zero_dist_seen),
    .saturated_seen_o(saturated_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sample the stall on the falling edge: it only moves on the rising edge,
  // so the value seen here is the one the next rising edge acts on.
  task automatic send(input body_cmd_t c);
    bit stalled;
    in_valid_i    <= 1'b1;
    action_i      <= c.action;
    own_x_i       <= c.own[0];
    own_y_i       <= c.own[1];
    own_z_i       <= c.own[2];
    vec_x_i       <= c.vec[0];
    vec_y_i       <= c.vec[1];
    vec_z_i       <= c.vec[2];
    other_valid_i <= c.other_valid;
    angle_in_i    <= c.angle;
    spin_in_i     <= c.spin;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    beats_sent++;
  endtask

  // Drop valid for a few cycles between bursts; inside a burst keep it high.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every outstanding result has left the block.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] ld, input logic [31:0] ad,
                          input logic [31:0] ms, input logic [31:0] gf);
    drain();
    write_reg(REG_LDAMP, ld);
    write_reg(REG_ADAMP, ad);
    write_reg(REG_MASS, ms);
    write_reg(REG_GFAC, gf);
  endtask

  // Mostly moderate magnitudes so the body evolves, now and then extremes.
  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      default: return $signed($urandom) >>> $urandom_range(6, 24);
    endcase
  endfunction

  function automatic body_cmd_t make_cmd(input logic [2:0] act);
    body_cmd_t c;
    c.action = act;
    for (int k = 0; k < 3; k++) begin
      c.own[k] = rnd_word();
      c.vec[k] = rnd_word();
    end
    c.other_valid = 1'b1;
    c.angle       = rnd_word();
    c.spin        = rnd_word();
    return c;
  endfunction

  function automatic body_cmd_t rand_cmd();
    body_cmd_t c;
    int        pick, sh;
    pick = $urandom_range(0, 99);
    if (pick < 35)      c = make_cmd(ACT_GRAV);
    else if (pick < 60) c = make_cmd(ACT_INTEG);
    else if (pick < 70) c = make_cmd(ACT_SPIN);
    else if (pick < 80) c = make_cmd(ACT_PUSH);
    else if (pick < 95) c = make_cmd(ACT_LOAD);
    else                c = make_cmd(3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI)));
    if (c.action == ACT_GRAV) begin
      c.other_valid = $urandom_range(0, 9) != 0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // nearby body: the regime where the term is actually visible
        sh = $urandom_range(8, 26);
        for (int k = 0; k < 3; k++)
          c.vec[k] = c.own[k] + ($signed($urandom) >>> (32 - sh));
      end else if (pick == 6) begin
        c.vec = c.own;
      end
    end
    return c;
  endfunction

  task automatic directed();
    body_cmd_t c;
    c = make_cmd(ACT_LOAD);
    c.vec = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd65536};
    send(c);
    c = make_cmd(ACT_PUSH);  // overflow both ways
    c.vec = '{32'sh7fff_ffff, 32'sh8000_0000, -32'sd65536};
    send(c);
    c = make_cmd(ACT_INTEG);
    c.own = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0};
    send(c);
    c = make_cmd(ACT_SPIN);
    c.spin = 32'sh7fff_ffff;
    send(c);
    send(c);                 // spin rate saturates
    c = make_cmd(ACT_INTEG);
    c.angle = 32'sh7fff_ffff;
    send(c);
    c = make_cmd(ACT_SPIN);
    c.spin = 32'sh8000_0000;
    send(c);
    c = make_cmd(ACT_GRAV);  // zero distance
    c.vec = c.own;
    send(c);
    c = make_cmd(ACT_GRAV);  // other body not counted
    c.other_valid = 1'b0;
    send(c);
    c = make_cmd(ACT_GRAV);  // distance beyond 31 bits
    c.own = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    c.vec = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send(c);
    c = make_cmd(ACT_GRAV);  // one LSB apart: huge term, saturates
    c.own = '{32'sd0, 32'sd0, 32'sd0};
    c.vec = '{-32'sd1, 32'sd1, 32'sd0};
    send(c);
    c = make_cmd(ACT_LOAD);
    c.vec = '{32'sd0, 32'sd0, 32'sd0};
    send(c);
    c = make_cmd(ACT_GRAV);  // ordinary term, unit distance on one axis
    c.own = '{32'sd0, 32'sd0, 32'sd0};
    c.vec = '{32'sd0, 32'sd0, 32'sd65536};
    send(c);
    for (int a = ACT_BAD_LO; a <= ACT_BAD_HI; a++) send(make_cmd(3'(a)));
    c = make_cmd(ACT_LOAD);
    c.vec = '{-32'sd1, -32'sd3, 32'sd5};
    send(c);
    send(make_cmd(ACT_INTEG)); // damping of small negative values
  endtask

  task automatic random_phase(input int count);
    hold_request = LONG_HOLD;  // output blocked while the sender keeps offering
    for (int i = 0; i < count; i++) begin
      send(rand_cmd());
      pace();
    end
  endtask

  // Receiver: random stall density that changes now and then, plus a long
  // hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    stall_pct   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      if (hold_request > 0) begin
        out_stall_i <= 1'b1;
        hold_request--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else if (!run_done) idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("rigid_body_gravity_integrator_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_GRAV;
    own_x_i       = '0;
    own_y_i       = '0;
    own_z_i       = '0;
    vec_x_i       = '0;
    vec_y_i       = '0;
    vec_z_i       = '0;
    other_valid_i = 1'b0;
    angle_in_i    = '0;
    spin_in_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    beats_sent    = 0;
    burst_left    = 0;
    hold_request  = 0;
    run_done      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values first
    directed();
    random_phase(400);

    // no damping at all, strongest gravity
    set_regs(32'd65536, 32'd65536, 32'h7fff_ffff, 32'h7fff_ffff);
    directed();
    random_phase(350);

    // everything zeroed: velocity dies on each integrate, gravity vanishes
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(200);

    // amplifying damping with full-width register values
    set_regs(32'h0001_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd65536);
    random_phase(250);

    // a random moderate setting
    set_regs($urandom_range(60000, 65536), $urandom_range(40000, 65536),
             $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20));
    random_phase(400);

    drain();
    run_done = 1'b1;
    repeat (250) @(posedge clk_i);

    $display("Sent %0d beats over five register settings, checked %0d results",
             beats_sent, beats_checked);
    $display("Zero-distance results: %0d, saturated results: %0d",
             zero_dist_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("rigid_body_gravity_integrator_top regression: pass");
    end else begin
      $display("rigid_body_gravity_integrator_top regression: fail");
    end
    $finish;
  end

endmodule
